/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the sorted priority queue
// no dependencies

package spq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_POP_RD
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_prev;
    logic wr_shift;
    logic ins_done;
    logic pop_done;
    logic res_empty;
    logic res_full;
  } cmd_t;

  typedef struct packed {
    logic in_ins;
    logic empty;
    logic full;
    logic shift;
    logic p_one;
  } stat_t;

endpackage

/* hdl/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// top level of the sorted priority queue: controller plus datapath
// depends on spq_pkg, spq_ctrl, spq_dp
//
//   channel   strobe / hold      fields
//   input     start, busy        in_kind, in_key, in_payload_tag
//   result    out_valid          out_status, out_key, out_tag, out_occupancy
//
// entries sit in a ring memory, largest key at the head
// an insert walks back from the tail over each entry with a smaller key
// full or empty reports come in the cycle after the item; one item in flight at a time
// synchronous reset empties the queue at once; results show for one cycle, no stall

module sorted_priority_queue #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [15:0] in_key,
  input  logic [31:0] in_payload_tag,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_key,
  output logic [31:0] out_tag,
  output logic [4:0]  out_occupancy
);
  import spq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  spq_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_payload_tag (in_payload_tag),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_key        (out_key),
    .out_tag        (out_tag),
    .out_occupancy  (out_occupancy)
  );

endmodule

/* hdl/spq_ctrl.sv */
`timescale 1ns / 1ps
// controller state machine for the sorted priority queue
// depends on spq_pkg

module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd,
  output logic          busy
);
  import spq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (stat.in_ins) begin
            if (stat.full) begin
              state_nxt = ST_IDLE;
            end else if (stat.empty) begin
              state_nxt = ST_INS_PUT;
            end else begin
              state_nxt = ST_INS_RD;
            end
          end else if (!stat.empty) begin
            state_nxt = ST_POP_RD;
          end
        end
      end
      ST_INS_RD: begin
        state_nxt = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (stat.shift) begin
          state_nxt = stat.p_one ? ST_INS_PUT : ST_INS_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        state_nxt = ST_IDLE;
      end
      ST_POP_RD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load      = 1'b1;
          cmd.res_full  = stat.in_ins && stat.full;
          cmd.res_empty = !stat.in_ins && stat.empty;
        end
      end
      ST_INS_RD: begin
        cmd.rd_prev = 1'b1;
      end
      ST_INS_CMP: begin
        cmd.wr_shift = stat.shift;
        cmd.ins_done = !stat.shift;
      end
      ST_INS_PUT: begin
        cmd.ins_done = 1'b1;
      end
      ST_POP_RD: begin
        cmd.pop_done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* hdl/spq_dp.sv */
`timescale 1ns / 1ps
// datapath for the sorted priority queue: entry memory, ring pointers, result registers
// depends on spq_pkg

module spq_dp #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_kind,
  input  logic [15:0]   in_key,
  input  logic [31:0]   in_payload_tag,
  input  spq_pkg::cmd_t  cmd,
  output spq_pkg::stat_t stat,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [15:0]   out_key,
  output logic [31:0]   out_tag,
  output logic [4:0]    out_occupancy
);
  import spq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int KW = KEY_BITS;

  logic [KW-1:0] key_mem [DEPTH];
  logic [31:0]   tag_mem [DEPTH];

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [KW-1:0] key_r;
  logic [31:0]   tag_r;
  logic [KW-1:0] rd_key_r;
  logic [31:0]   rd_tag_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [15:0]   out_key_r;
  logic [31:0]   out_tag_r;
  logic [4:0]    out_occupancy_r;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [KW-1:0] wr_key;
  logic [31:0]   wr_tag;
  logic [31:0]   key_in_ext;
  logic [31:0]   key_out_ext;
  logic [31:0]   occ_ext;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [SW-1:0] sum;
    sum = {1'b0, h} + SW'(p);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign key_in_ext  = 32'(in_key);
  assign key_out_ext = 32'(rd_key_r);

  assign rd_addr = cmd.rd_prev ? phys(head_r, p_r - CW'(1)) : head_r;
  assign wr_addr = phys(head_r, p_r);
  assign wr_en   = cmd.wr_shift | cmd.ins_done;
  assign wr_key  = cmd.wr_shift ? rd_key_r : key_r;
  assign wr_tag  = cmd.wr_shift ? rd_tag_r : tag_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      tag_mem[wr_addr] <= wr_tag;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_tag_r <= tag_mem[rd_addr];
  end

  assign stat.in_ins = (in_kind == KIND_INSERT);
  assign stat.empty  = (count_r == '0);
  assign stat.full   = (count_r == CW'(DEPTH));
  assign stat.shift  = (rd_key_r < key_r);
  assign stat.p_one  = (p_r == CW'(1));

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    p_nxt     = p_r;
    if (cmd.load) begin
      p_nxt = count_r;
    end
    if (cmd.wr_shift) begin
      p_nxt = p_r - CW'(1);
    end
    if (cmd.ins_done) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.pop_done) begin
      count_nxt = count_r - CW'(1);
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    end
  end

  assign occ_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      p_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      p_r         <= p_nxt;
      out_valid_r <= cmd.ins_done | cmd.pop_done | cmd.res_empty | cmd.res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_in_ext[KW-1:0];
      tag_r <= in_payload_tag;
    end
    out_occupancy_r <= occ_ext[4:0];
    if (cmd.pop_done) begin
      out_status_r <= STATUS_OK;
      out_key_r    <= key_out_ext[15:0];
      out_tag_r    <= rd_tag_r;
    end else begin
      out_key_r <= '0;
      out_tag_r <= '0;
      if (cmd.res_empty) begin
        out_status_r <= STATUS_EMPTY;
      end else if (cmd.res_full) begin
        out_status_r <= STATUS_FULL;
      end else begin
        out_status_r <= STATUS_OK;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_tag       = out_tag_r;
  assign out_occupancy = out_occupancy_r;

endmodule

/* hdl/spq_chk.sv */
`timescale 1ns / 1ps
// port checker for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue

module spq_chk #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [15:0] out_key,
  input logic [31:0] out_tag,
  input logic [4:0]  out_occupancy
);
  import spq_pkg::*;

  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  // an accepted item either keeps the block busy or reports at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither in progress nor reported");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_EMPTY
                   || out_status == STATUS_FULL))
    else $error("unknown status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |-> (out_key == '0 && out_tag == '0))
    else $error("failed item carries data");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_EMPTY) |-> (out_occupancy == '0))
    else $error("empty report with entries stored");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_FULL) |-> (out_occupancy == DEPTH_W[4:0]))
    else $error("full report below capacity");

endmodule

bind sorted_priority_queue spq_chk #(.DEPTH(DEPTH)) u_spq_chk (.*);

/* verif/sorted_priority_queue_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for sorted_priority_queue: directed and random insert and pop items
// checked against a behavioural model of the sorted list held in the bench
// depends on spq_pkg and sorted_priority_queue

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic        kind;
    logic [15:0] key;
    logic [31:0] tag;
    int unsigned gap;
    bit          drain;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] key;
    logic [31:0] tag;
    logic [4:0]  occ;
  } pop_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = KIND_INSERT;
  logic [15:0] in_key = '0;
  logic [31:0] in_payload_tag = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_key;
  logic [31:0] out_tag;
  logic [4:0]  out_occupancy;

  cmd_item_t   cmd_backlog[$];
  pop_result_t pending_results[$];

  logic [15:0] model_keys[QDEPTH];
  logic [31:0] model_tags[QDEPTH];
  int unsigned model_count = 0;

  logic        in_taken = 1'b0;
  int unsigned idle_left = 0;
  bit          gap_armed = 1'b0;
  int unsigned mismatches = 0;

  sorted_priority_queue #(.DEPTH(QDEPTH), .KEY_BITS(16)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_payload_tag (in_payload_tag),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_key        (out_key),
    .out_tag        (out_tag),
    .out_occupancy  (out_occupancy)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic pop_result_t predict_result(logic kind, logic [15:0] key, logic [31:0] tag);
    pop_result_t r;
    int unsigned pos;
    r = '{status: STATUS_OK, key: '0, tag: '0, occ: '0};
    if (kind == KIND_INSERT) begin
      if (model_count >= QDEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < model_count && model_keys[pos] >= key) pos++;
        for (int i = model_count; i > pos; i--) begin
          model_keys[i] = model_keys[i-1];
          model_tags[i] = model_tags[i-1];
        end
        model_keys[pos] = key;
        model_tags[pos] = tag;
        model_count++;
      end
    end else if (model_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.key = model_keys[0];
      r.tag = model_tags[0];
      for (int i = 1; i < model_count; i++) begin
        model_keys[i-1] = model_keys[i];
        model_tags[i-1] = model_tags[i];
      end
      model_count--;
    end
    r.occ = model_count[4:0];
    return r;
  endfunction

  task automatic log_mismatch(string what, pop_result_t want, pop_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected status %0d key %h tag %h occ %0d, got status %0d key %h tag %h occ %0d",
               what, want.status, want.key, want.tag, want.occ,
               got.status, got.key, got.tag, got.occ);
  endtask

  task automatic add_cmd(logic kind, logic [15:0] key, logic [31:0] tag, int unsigned gap,
                         bit drain);
    cmd_item_t c;
    c.kind = kind;
    c.key = key;
    c.tag = tag;
    c.gap = gap;
    c.drain = drain;
    cmd_backlog.push_back(c);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !in_taken) begin
    end else if (cmd_backlog.size() == 0) begin
      start <= 1'b0;
    end else begin
      if (!gap_armed) begin
        idle_left = cmd_backlog[0].gap;
        gap_armed = 1'b1;
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cmd_backlog[0].drain && (pending_results.size() != 0 || busy)) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_kind <= cmd_backlog[0].kind;
        in_key <= cmd_backlog[0].key;
        in_payload_tag <= cmd_backlog[0].tag;
        void'(cmd_backlog.pop_front());
        gap_armed = 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    pop_result_t want;
    pop_result_t got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= start && !busy;
      if (out_valid) begin
        got = '{status: out_status, key: out_key, tag: out_tag, occ: out_occupancy};
        if (pending_results.size() == 0) begin
          log_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (want !== got) log_mismatch("result", want, got);
        end
      end
      if (start && !busy)
        pending_results.push_back(predict_result(in_kind, in_key, in_payload_tag));
    end
  end

  initial begin
    #5000000;
    $display("sorted_priority_queue: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned made;
    int unsigned n;
    int unsigned pct;
    bit idle;
    bit ties;
    bit first;
    logic kind;
    logic [15:0] key;

    // directed items
    add_cmd(KIND_POP, 16'hffff, 32'hffff_ffff, 0, 0);
    add_cmd(KIND_INSERT, 16'h0000, 32'h0000_0000, 0, 0);
    add_cmd(KIND_INSERT, 16'hffff, 32'hffff_ffff, 0, 0);
    add_cmd(KIND_INSERT, 16'h1234, 32'haaaa_0001, 1, 0);
    add_cmd(KIND_INSERT, 16'h1234, 32'haaaa_0002, 0, 0);
    add_cmd(KIND_INSERT, 16'h1234, 32'haaaa_0003, 2, 0);
    add_cmd(KIND_INSERT, 16'h8000, 32'h5555_5555, 0, 0);
    for (int i = 0; i < 7; i++) add_cmd(KIND_POP, 16'h0000, 32'h0000_0000, 0, 0);
    add_cmd(KIND_POP, 16'h5a5a, 32'hdead_beef, 0, 1);

    // random sequences: fill bursts and mixed traffic
    made = 0;
    first = 1'b1;
    while (made < 385) begin
      idle = $urandom_range(0, 1);
      ties = $urandom_range(0, 1);
      if ($urandom_range(0, 2) == 0) begin
        n = 16 + $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          key = ties ? 16'($urandom_range(0, 7)) : 16'($urandom);
          add_cmd(KIND_INSERT, key, $urandom, idle ? $urandom_range(0, 8) : 0,
                  i == 0 && (first || $urandom_range(0, 2) == 0));
          first = 1'b0;
        end
        for (int i = 0; i <= n; i++)
          add_cmd(KIND_POP, 16'($urandom), $urandom, idle ? $urandom_range(0, 8) : 0, 0);
        made += 2 * n + 1;
      end else begin
        pct = $urandom_range(30, 70);
        for (int i = 0; i < 24; i++) begin
          kind = ($urandom_range(0, 99) < pct) ? KIND_INSERT : KIND_POP;
          case ($urandom_range(0, 9))
            0: key = 16'h0000;
            1: key = 16'hffff;
            default: key = ties ? 16'($urandom_range(0, 7)) : 16'($urandom);
          endcase
          add_cmd(kind, key, $urandom, idle ? $urandom_range(0, 8) : 0,
                  i == 0 && (first || $urandom_range(0, 2) == 0));
          first = 1'b0;
        end
        made += 24;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmd_backlog.size() != 0 || start || pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("sorted_priority_queue: match");
    else
      $display("sorted_priority_queue: mismatch");
    $finish;
  end

endmodule
